[hw/rtl/pidc_pkg.sv]
// shared types, constants and saturation helpers for the pid controller
package pidc_pkg;

  localparam int DATA_W    = 32;
  localparam int SUM_W     = 48;
  localparam int FRAC_W    = 16;
  localparam int MUL_A_W   = DATA_W + 1;
  localparam int PROD_W    = MUL_A_W + DATA_W;
  localparam int TERM_W    = PROD_W - FRAC_W;
  localparam int TOTAL_W   = TERM_W + 2;
  localparam int CFG_IDX_W = 2;

  // divider retires two quotient bits per cycle
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_STEPS = SUM_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_TIME    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_MODE = 2'd3;

  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;
  localparam logic MODE_RAW  = 1'b1;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] mag;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] x);
    logic signed [SUM_W-1:0] r;
    if (x[SUM_W] != x[SUM_W-1]) begin
      r = x[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      r = x[SUM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [TOTAL_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if ((&x[TOTAL_W-1:DATA_W-1]) || !(|x[TOTAL_W-1:DATA_W-1])) begin
      r = x[DATA_W-1:0];
    end else begin
      r = x[TOTAL_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[hw/rtl/pidc_in_if.sv]
// step channel: command and error sample
interface pidc_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [pidc_pkg::DATA_W-1:0] error_in;

  modport source (output valid, cmd, error_in, input ready);
  modport sink   (input valid, cmd, error_in, output ready);
endinterface

[hw/rtl/pidc_out_if.sv]
// result channel: control output
interface pidc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pidc_pkg::DATA_W-1:0] control_out;

  modport source (output valid, control_out, input ready);
  modport sink   (input valid, control_out, output ready);
endinterface

[hw/rtl/pidc_mul.sv]
// shared signed multiplier with registered product
module pidc_mul (
  input  logic                                 clk_i,
  input  logic signed [pidc_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [pidc_pkg::DATA_W-1:0]   b_i,
  output logic signed [pidc_pkg::PROD_W-1:0]   prod_o
);

  logic signed [pidc_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= pidc_pkg::PROD_W'(a_i) * pidc_pkg::PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

[hw/rtl/pidc_div.sv]
// iterative restoring divider: mag * 2^16 / den, capped to the sum range
module pidc_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pidc_pkg::div_req_t   req_i,
  output pidc_pkg::div_rsp_t   rsp_o
);

  localparam int SW = pidc_pkg::SUM_W;
  localparam int DW = pidc_pkg::DATA_W;
  localparam int FW = pidc_pkg::FRAC_W;
  localparam int HW = SW - DW;

  logic                          busy_q;
  logic                          done_q;
  logic                          ovf_q;
  logic [pidc_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [DW-1:0]                 rem_q, rem_d;
  logic [DW-1:0]                 den_q;
  logic [SW-1:0]                 sh_q, sh_d;
  logic [SW-1:0]                 quot_q;
  logic                          ovf_start;

  // high part of the dividend already at or above den means quotient >= 2^48
  assign ovf_start = {{(DW-HW){1'b0}}, req_i.mag[SW-1:DW]} >= req_i.den;

  always_comb begin : div_step
    logic [DW:0] t;
    logic        qb;
    rem_d = rem_q;
    sh_d  = sh_q;
    for (int k = 0; k < pidc_pkg::DIV_BITS_PER_CYCLE; k++) begin
      t = {rem_d, sh_d[SW-1]};
      if (t >= {1'b0, den_q}) begin
        t  = t - {1'b0, den_q};
        qb = 1'b1;
      end else begin
        qb = 1'b0;
      end
      rem_d = t[DW-1:0];
      sh_d  = {sh_d[SW-2:0], qb};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.start) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == pidc_pkg::DIV_CNT_W'(pidc_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (req_i.start) begin
        den_q <= req_i.den;
        ovf_q <= ovf_start;
        rem_q <= ovf_start ? '0 : {{(DW-HW){1'b0}}, req_i.mag[SW-1:DW]};
        sh_q  <= {req_i.mag[DW-1:0], {FW{1'b0}}};
      end
    end else begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
      if (cnt_q == pidc_pkg::DIV_CNT_W'(pidc_pkg::DIV_STEPS - 1)) begin
        quot_q <= (ovf_q || sh_d[SW-1]) ? pidc_pkg::SUM_MAX : sh_d;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

[hw/rtl/pid_controller_two_integral_modes.sv]
// top level: discrete pid controller with two integral modes, Q16.16
//
// step_i carries one word per control step: cmd selects a step or a clear of
// the controller state, error_in is the error sample. result_o returns one
// word, control_out = P + I + D saturated to 32 bits, for every step; a clear
// returns nothing. Gains, integral time and integral mode are written through
// the cfg port (cfg_we_i, cfg_idx_i, cfg_data_i); the user must write them only
// while the block is idle, which the block itself does not enforce.
// One step word is in work at a time; step_i.ready is high only when the
// sequencer is idle. A taken step word goes through the P and D products on
// one shared multiplier, then one divider pass with integral mode 0 or two
// with mode 1, then the sum state that writes the result word; when the
// integral time is zero the divider is skipped and the integral sums are
// cleared. The shared divider retires two quotient bits a cycle over 48 bits,
// and a clear is handled entirely in the idle state.
// The finished word waits in an output register; if the receiver stalls, the
// next step word is still taken and its result holds until that register
// frees up. Reset zeroes the configuration registers, both integral sums and
// the previous error, and leaves no word pending on result_o.
module pid_controller_two_integral_modes (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  pidc_in_if.sink                              step_i,
  pidc_out_if.source                           result_o,
  input  logic                                 cfg_we_i,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pidc_pkg::DATA_W-1:0]          cfg_data_i
);

  localparam int DW = pidc_pkg::DATA_W;
  localparam int SW = pidc_pkg::SUM_W;
  localparam int TW = pidc_pkg::TERM_W;
  localparam int OW = pidc_pkg::TOTAL_W;
  localparam int FW = pidc_pkg::FRAC_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_DIV_A,
    ST_WAIT_A,
    ST_WAIT_B,
    ST_SUM
  } state_e;

  state_e state_q;

  logic signed [DW-1:0] kp_q, td_q;
  logic [DW-1:0]        ti_q;
  logic                 mode_q;

  logic signed [DW-1:0] e_q, last_q;
  logic signed [SW-1:0] scaled_q, raw_q, i_q;
  logic signed [TW-1:0] p_q, d_q;
  logic                 neg_q;
  pidc_pkg::div_req_t   div_req_q;
  pidc_pkg::div_rsp_t   div_rsp;
  logic                 out_valid_q;
  logic signed [DW-1:0] out_data_q;

  logic signed [pidc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [DW-1:0]                mul_b;
  logic signed [pidc_pkg::PROD_W-1:0]  prod;

  logic signed [SW-1:0] quot_s, scaled_new, raw_new;
  logic signed [OW-1:0] total;
  logic                 step_acc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= '0;
      ti_q   <= '0;
      td_q   <= '0;
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pidc_pkg::CFG_PROP_GAIN:     kp_q   <= cfg_data_i;
        pidc_pkg::CFG_INTEGRAL_TIME: ti_q   <= cfg_data_i;
        pidc_pkg::CFG_DERIV_TIME:    td_q   <= cfg_data_i;
        pidc_pkg::CFG_INTEGRAL_MODE: mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // multiplier operands: kp * e first, then td * (e - last)
  always_comb begin
    if (state_q == ST_MUL_D) begin
      mul_a = {e_q[DW-1], e_q} - {last_q[DW-1], last_q};
      mul_b = td_q;
    end else begin
      mul_a = {e_q[DW-1], e_q};
      mul_b = kp_q;
    end
  end

  pidc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  pidc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  assign quot_s     = neg_q ? -$signed(div_rsp.quot) : $signed(div_rsp.quot);
  assign scaled_new = pidc_pkg::sat_sum({scaled_q[SW-1], scaled_q} + {quot_s[SW-1], quot_s});
  assign raw_new    = pidc_pkg::sat_sum({raw_q[SW-1], raw_q} + {{(SW+1-DW){e_q[DW-1]}}, e_q});
  assign total      = {{(OW-TW){p_q[TW-1]}}, p_q} + {{(OW-SW){i_q[SW-1]}}, i_q}
                    + {{(OW-TW){d_q[TW-1]}}, d_q};

  assign step_acc       = step_i.valid && step_i.ready;
  assign step_i.ready   = (state_q == ST_IDLE);
  assign result_o.valid = out_valid_q;
  assign result_o.control_out = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      scaled_q        <= '0;
      raw_q           <= '0;
      last_q          <= '0;
      div_req_q.start <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      div_req_q.start <= 1'b0;
      if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (step_acc) begin
            e_q <= step_i.error_in;
            if (step_i.cmd == pidc_pkg::CMD_CLEAR) begin
              scaled_q <= '0;
              raw_q    <= '0;
              last_q   <= '0;
            end else begin
              state_q <= ST_MUL_P;
            end
          end
        end
        ST_MUL_P: state_q <= ST_MUL_D;
        ST_MUL_D: begin
          p_q     <= prod[pidc_pkg::PROD_W-1:FW];
          state_q <= ST_DIV_A;
        end
        ST_DIV_A: begin
          d_q    <= prod[pidc_pkg::PROD_W-1:FW];
          last_q <= e_q;
          if (ti_q == '0) begin
            scaled_q <= '0;
            raw_q    <= '0;
            i_q      <= '0;
            state_q  <= ST_SUM;
          end else begin
            div_req_q.start <= 1'b1;
            div_req_q.mag   <= e_q[DW-1] ? SW'(-{{(SW-DW){e_q[DW-1]}}, e_q})
                                         : {{(SW-DW){1'b0}}, e_q};
            div_req_q.den   <= ti_q;
            neg_q           <= e_q[DW-1];
            state_q         <= ST_WAIT_A;
          end
        end
        ST_WAIT_A: begin
          if (div_rsp.done) begin
            scaled_q <= scaled_new;
            raw_q    <= raw_new;
            if (mode_q == pidc_pkg::MODE_RAW) begin
              // second pass divides the updated raw sum
              div_req_q.start <= 1'b1;
              div_req_q.mag   <= raw_new[SW-1] ? -raw_new : raw_new;
              neg_q           <= raw_new[SW-1];
              state_q         <= ST_WAIT_B;
            end else begin
              i_q     <= scaled_new;
              state_q <= ST_SUM;
            end
          end
        end
        ST_WAIT_B: begin
          if (div_rsp.done) begin
            i_q     <= quot_s;
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (!out_valid_q || result_o.ready) begin
            out_data_q  <= pidc_pkg::sat_out(total);
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_done_only_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_WAIT_A || state_q == ST_WAIT_B))
    else $error("divider finished outside a wait state");

  a_result_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_SUM))
    else $error("result word raised outside the sum state");

  a_clear_gives_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_acc && step_i.cmd == pidc_pkg::CMD_CLEAR) |=> !$rose(out_valid_q))
    else $error("clear command produced a result word");

  a_start_only_when_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_q.start |-> $past(state_q == ST_DIV_A || state_q == ST_WAIT_A))
    else $error("divider started from an unexpected state");

endmodule

[dv/tb_pid_controller_two_integral_modes.sv]
// self-checking testbench for the pid controller: directed table, then random register phases
module tb_pid_controller_two_integral_modes;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RST_CYCLES    = 5;
  localparam int RAND_WORDS    = 1525;
  localparam int IDLE_GAP      = 80;
  localparam int TAIL_CYCLES   = 100;
  localparam int RX_HOLD       = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int N_DIR         = 40;

  localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint OUT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  localparam logic MODE_SCALED = ~pidc_pkg::MODE_RAW;

  typedef enum logic [1:0] {ROW_CFG, ROW_STEP, ROW_CHECKED, ROW_CLEAR} row_kind_e;

  typedef struct packed {
    row_kind_e                        kind;
    logic [pidc_pkg::CFG_IDX_W-1:0]   idx;
    logic [pidc_pkg::DATA_W-1:0]      val;
    logic [pidc_pkg::DATA_W-1:0]      want;
  } stim_row_t;

  // typed-in results only where the gains make them obvious
  stim_row_t dir_rows [N_DIR] = '{
    '{ROW_CHECKED, '0, 32'h7FFF_FFFF, 32'h0000_0000},
    '{ROW_CHECKED, '0, 32'h8000_0000, 32'h0000_0000},
    '{ROW_CLEAR,   '0, 32'h0000_0000, '0},
    '{ROW_CFG, pidc_pkg::CFG_PROP_GAIN, 32'h0001_0000, '0},
    '{ROW_CHECKED, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{ROW_CHECKED, '0, 32'h8000_0000, 32'h8000_0000},
    '{ROW_CFG, pidc_pkg::CFG_PROP_GAIN, 32'h7FFF_FFFF, '0},
    '{ROW_CHECKED, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{ROW_CHECKED, '0, 32'h8000_0000, 32'h8000_0000},
    '{ROW_CFG, pidc_pkg::CFG_PROP_GAIN, 32'h8000_0000, '0},
    '{ROW_CHECKED, '0, 32'h8000_0000, 32'h7FFF_FFFF},
    '{ROW_CFG, pidc_pkg::CFG_PROP_GAIN, 32'h0000_8000, '0},
    '{ROW_CFG, pidc_pkg::CFG_DERIV_TIME, 32'h7FFF_FFFF, '0},
    '{ROW_STEP,    '0, 32'h0000_0100, '0},
    '{ROW_CFG, pidc_pkg::CFG_DERIV_TIME, 32'h8000_0000, '0},
    '{ROW_STEP,    '0, 32'h7FFF_FFFF, '0},
    '{ROW_STEP,    '0, 32'h8000_0000, '0},
    '{ROW_CFG, pidc_pkg::CFG_DERIV_TIME, 32'h0000_4000, '0},
    '{ROW_CFG, pidc_pkg::CFG_INTEGRAL_TIME, 32'h0001_0000, '0},
    '{ROW_STEP,    '0, 32'h0001_0000, '0},
    '{ROW_STEP,    '0, 32'h0003_0000, '0},
    '{ROW_STEP,    '0, 32'hFFFE_0000, '0},
    '{ROW_CLEAR,   '0, 32'h0000_0000, '0},
    '{ROW_STEP,    '0, 32'h0002_0000, '0},
    '{ROW_CFG, pidc_pkg::CFG_INTEGRAL_MODE, 32'(pidc_pkg::MODE_RAW), '0},
    '{ROW_STEP,    '0, 32'h0005_0000, '0},
    '{ROW_STEP,    '0, 32'hFFFF_C000, '0},
    '{ROW_CFG, pidc_pkg::CFG_INTEGRAL_TIME, 32'hFFFF_FFFF, '0},
    '{ROW_STEP,    '0, 32'h7FFF_FFFF, '0},
    '{ROW_CFG, pidc_pkg::CFG_INTEGRAL_TIME, 32'h0000_0001, '0},
    '{ROW_STEP,    '0, 32'h7FFF_FFFF, '0},
    '{ROW_STEP,    '0, 32'h7FFF_FFFF, '0},
    '{ROW_STEP,    '0, 32'h8000_0000, '0},
    '{ROW_CFG, pidc_pkg::CFG_INTEGRAL_MODE, 32'(MODE_SCALED), '0},
    '{ROW_STEP,    '0, 32'h7FFF_FFFF, '0},
    '{ROW_STEP,    '0, 32'h8000_0000, '0},
    '{ROW_CFG, pidc_pkg::CFG_INTEGRAL_TIME, 32'h0000_0000, '0},
    '{ROW_STEP,    '0, 32'h0001_0000, '0},
    '{ROW_CFG, pidc_pkg::CFG_INTEGRAL_TIME, 32'h0002_0000, '0},
    '{ROW_STEP,    '0, 32'h0001_0000, '0}
  };

  logic clk_i;
  logic rst_ni;
  logic                           cfg_we_i;
  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [pidc_pkg::DATA_W-1:0]    cfg_data_i;

  pidc_in_if  step_if ();
  pidc_out_if res_if ();

  pid_controller_two_integral_modes i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step_if),
    .result_o   (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // mirror of the gains and integral state
  longint      kp, td;
  logic [31:0] ti;
  logic        raw_mode;
  longint      i_acc, err_acc, prev_err;

  logic [pidc_pkg::DATA_W-1:0] pending_control [$];

  int  n_steps, n_clears, n_writes, n_checked, n_fail, n_rand, n_phases;
  bit  sent_since_cfg;
  bit  burst;
  bit  rx_hold_req;

  function automatic void enqueue_word(input logic [pidc_pkg::DATA_W-1:0] w);
    pending_control.insert(pending_control.size(), w);
  endfunction

  function automatic longint clamp48(input longint x);
    if (x > ACC_MAX) return ACC_MAX;
    if (x < ACC_MIN) return ACC_MIN;
    return x;
  endfunction

  // x * 2^16 / den toward zero, magnitude capped at the accumulator max
  function automatic longint scale_by_ti(input longint x, input logic [31:0] den);
    logic [63:0] m, q, r, mag;
    m = (x < 0) ? -x : x;
    q = m / den;
    r = m % den;
    if (q >= 64'h8000_0000) mag = ACC_MAX;
    else mag = (q << 16) + (r << 16) / den;
    if (mag > ACC_MAX) mag = ACC_MAX;
    return (x < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [pidc_pkg::DATA_W-1:0] compute_control(
      input logic signed [pidc_pkg::DATA_W-1:0] err);
    longint e, p, ival, d, total;
    e = err;
    if (ti == '0) begin
      i_acc   = 0;
      err_acc = 0;
      ival    = 0;
    end else begin
      i_acc   = clamp48(i_acc + scale_by_ti(e, ti));
      err_acc = clamp48(err_acc + e);
      ival    = (raw_mode == pidc_pkg::MODE_RAW) ? scale_by_ti(err_acc, ti) : i_acc;
    end
    d = ((e - prev_err) * td) >>> 16;
    prev_err = e;
    p = (e * kp) >>> 16;
    total = p + ival + d;
    if (total > OUT_MAX) total = OUT_MAX;
    if (total < OUT_MIN) total = OUT_MIN;
    return 32'(total);
  endfunction

  function automatic void clear_mirror_state();
    i_acc    = 0;
    err_acc  = 0;
    prev_err = 0;
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom();
      default: return 32'($urandom_range(0, 32'h6_0000)) - 32'h3_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_ti();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return $urandom();
      default: return $urandom_range(32'h800, 32'h8_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_error();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3, 4, 5: return $urandom();
      default: return 32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
    endcase
  endfunction

  function automatic int pick_gap();
    int sel;
    if (burst) return 0;
    sel = $urandom_range(0, 19);
    if (sel == 0) return $urandom_range(20, 80);
    if (sel < 10) return 0;
    return $urandom_range(1, 3);
  endfunction

  task automatic write_reg(input logic [pidc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pidc_pkg::DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      pidc_pkg::CFG_PROP_GAIN:     kp = $signed(val);
      pidc_pkg::CFG_INTEGRAL_TIME: ti = val;
      pidc_pkg::CFG_DERIV_TIME:    td = $signed(val);
      pidc_pkg::CFG_INTEGRAL_MODE: raw_mode = val[0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    step_if.valid <= 1'b0;
    while (pending_control.size() != 0) @(posedge clk_i);
  endtask

  // a clear leaves no word behind, so give the sequencer time to settle
  task automatic wait_idle();
    drain_results();
    repeat (IDLE_GAP) @(posedge clk_i);
    sent_since_cfg = 1'b0;
  endtask

  task automatic send_word(input logic cmd, input logic [pidc_pkg::DATA_W-1:0] err,
                           input bit typed, input logic [pidc_pkg::DATA_W-1:0] typed_val,
                           input int gap);
    logic [pidc_pkg::DATA_W-1:0] pred;
    if (gap > 0) begin
      @(negedge clk_i);
      step_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    step_if.valid    <= 1'b1;
    step_if.cmd      <= cmd;
    step_if.error_in <= err;
    do @(posedge clk_i); while (!step_if.ready);
    sent_since_cfg = 1'b1;
    if (cmd == pidc_pkg::CMD_CLEAR) begin
      clear_mirror_state();
      n_clears++;
    end else begin
      pred = compute_control(err);
      enqueue_word(typed ? typed_val : pred);
      n_steps++;
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (RX_HOLD) @(negedge clk_i);
      end else if (burst) begin
        res_if.ready <= 1'b1;
      end else begin
        if ($urandom_range(0, 49) == 0) stall = $urandom_range(20, 80);
        else if ($urandom_range(0, 2) == 0) stall = $urandom_range(1, 3);
        else stall = 0;
        if (stall == 0) begin
          res_if.ready <= 1'b1;
        end else begin
          res_if.ready <= 1'b0;
          repeat (stall - 1) @(negedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    logic [pidc_pkg::DATA_W-1:0] want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_control.size() == 0) begin
        $error("control_out: no word expected, got %h", res_if.control_out);
        n_fail++;
      end else begin
        want = pending_control.pop_front();
        n_checked++;
        if (res_if.control_out !== want) begin
          $error("control_out: expected %h, got %h", want, res_if.control_out);
          n_fail++;
        end
      end
    end
  end

  // ends the run if neither channel moves a word for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((step_if.valid && step_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no handshake for %0d cycles, %0d words outstanding",
             QUIET_LIMIT, pending_control.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int len;
    logic cmd;
    step_if.valid    = 1'b0;
    step_if.cmd      = pidc_pkg::CMD_STEP;
    step_if.error_in = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = pidc_pkg::CFG_PROP_GAIN;
    cfg_data_i = '0;
    rst_ni     = 1'b0;
    kp = 0;
    td = 0;
    ti = '0;
    raw_mode = MODE_SCALED;
    clear_mirror_state();
    burst = 1'b0;
    rx_hold_req = 1'b0;
    sent_since_cfg = 1'b0;
    n_steps = 0; n_clears = 0; n_writes = 0; n_checked = 0; n_fail = 0;
    n_rand = 0; n_phases = 0;

    repeat (RST_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          if (sent_since_cfg) wait_idle();
          write_reg(dir_rows[i].idx, dir_rows[i].val);
        end
        ROW_CLEAR:   send_word(pidc_pkg::CMD_CLEAR, dir_rows[i].val, 1'b0, '0, pick_gap());
        ROW_CHECKED: send_word(pidc_pkg::CMD_STEP, dir_rows[i].val, 1'b1, dir_rows[i].want,
                               pick_gap());
        default:     send_word(pidc_pkg::CMD_STEP, dir_rows[i].val, 1'b0, '0, pick_gap());
      endcase
    end

    while (n_rand < RAND_WORDS) begin
      if (sent_since_cfg) wait_idle();
      burst = ($urandom_range(0, 3) == 0);
      write_reg(pidc_pkg::CFG_PROP_GAIN, pick_gain());
      write_reg(pidc_pkg::CFG_INTEGRAL_TIME, pick_ti());
      write_reg(pidc_pkg::CFG_DERIV_TIME, pick_gain());
      write_reg(pidc_pkg::CFG_INTEGRAL_MODE, $urandom());
      len = $urandom_range(40, 120);
      for (int k = 0; k < len && n_rand < RAND_WORDS; k++) begin
        // one long receiver hold-off while words keep coming
        if (n_phases == 1 && k == 10) rx_hold_req = 1'b1;
        if (n_phases == 3 && k == len / 2) drain_results();
        cmd = ($urandom_range(0, 24) == 0) ? pidc_pkg::CMD_CLEAR : pidc_pkg::CMD_STEP;
        send_word(cmd, pick_error(), 1'b0, '0, pick_gap());
        n_rand++;
      end
      n_phases++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_control.size() != 0) begin
      $error("control_out: %0d expected words never arrived", pending_control.size());
      n_fail++;
    end

    $display("drove %0d control steps and %0d state clears over %0d register writes",
             n_steps, n_clears, n_writes);
    $display("compared %0d control words across %0d random register settings, %0d mismatches",
             n_checked, n_phases, n_fail);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_in_if.sv
hw/rtl/pidc_out_if.sv
hw/rtl/pidc_mul.sv
hw/rtl/pidc_div.sv
hw/rtl/pid_controller_two_integral_modes.sv
dv/tb_pid_controller_two_integral_modes.sv
